/* design/fba_pkg.sv */
// Shared types, widths and codes for the fixed block pool allocator.
package fba_pkg;

    localparam int IDX_W          = 10;
    localparam int CNT_W          = 11;
    localparam int BYTES_W        = 16;
    localparam int OFS_W          = 26;
    localparam int CFG_W          = 16;
    localparam int MAX_BLOCKS_DEF = 1024;
    localparam int POOL_LIMIT     = 1024;
    localparam int QUEUE_DEPTH    = 2;

    localparam logic [CNT_W-1:0]   CNT_RESET   = 11'd1024;
    localparam logic [BYTES_W-1:0] BYTES_RESET = 16'd16;
    localparam logic [CNT_W-1:0]   CNT_SAT     = 11'h7FF;

    // configuration register indexes
    localparam logic CFG_BLOCK_COUNT = 1'b0;
    localparam logic CFG_BLOCK_BYTES = 1'b1;

    typedef enum logic {
        REQ_ALLOC = 1'b0,
        REQ_FREE  = 1'b1
    } t_req;

    typedef struct packed {
        t_req             req_type;
        logic [IDX_W-1:0] block_index;
    } t_cmd;

    typedef enum logic {
        BK_EXEC = 1'b0,
        BK_LOAD = 1'b1
    } t_back_state;

endpackage

/* design/fixed_block_pool_allocator.sv */
// Top level of the fixed block pool allocator: request queue plus executor.
//
// Usage: raise start with i_req_type and i_block_index; the word is taken at a
// rising edge where start is high and busy is low. Allocate words (type 0)
// pop a block from the free list; free words (type 1) push i_block_index.
// Each word gives exactly one result, shown on o_granted, o_given_index,
// o_byte_offset and o_blocks_free for one cycle while o_done is high.
// An accepted word passes through the request queue to the executor, which
// registers its result. A free is done in the execute state alone, as is a
// refused allocate or one that takes the last free block; any other allocate
// also passes through a load state, since the new head comes from a registered
// read of the link memory. A two-word queue lets requests arrive while the
// executor works; busy is high while it is full. Results cannot be held off.
// Configuration (i_cfg_we, i_cfg_index, i_cfg_data) is to be written by the
// user only while no request is in flight; the block does not enforce this.
// Every write re-initializes the pool, as does reset. Reset: synchronous,
// active low; block count 1024, block size 16 bytes, all blocks free. The link
// memory needs no clearing pass: links are built lazily, one per allocate.
module fixed_block_pool_allocator #(
    parameter int MAX_BLOCKS = fba_pkg::MAX_BLOCKS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        i_req_type,
    input  logic [fba_pkg::IDX_W-1:0]   i_block_index,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_index,
    input  logic [fba_pkg::CFG_W-1:0]   i_cfg_data,
    output logic                        o_done,
    output logic                        o_granted,
    output logic [fba_pkg::IDX_W-1:0]   o_given_index,
    output logic [fba_pkg::OFS_W-1:0]   o_byte_offset,
    output logic [fba_pkg::CNT_W-1:0]   o_blocks_free
);

    logic          w_cmd_valid;
    fba_pkg::t_cmd w_cmd;
    logic          w_pop;

    fba_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .i_req_type    (i_req_type),
        .i_block_index (i_block_index),
        .busy          (busy),
        .o_cmd_valid   (w_cmd_valid),
        .o_cmd         (w_cmd),
        .i_pop         (w_pop)
    );

    fba_back #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_cmd_valid   (w_cmd_valid),
        .i_cmd         (w_cmd),
        .o_pop         (w_pop),
        .o_done        (o_done),
        .o_granted     (o_granted),
        .o_given_index (o_given_index),
        .o_byte_offset (o_byte_offset),
        .o_blocks_free (o_blocks_free)
    );

endmodule

/* design/fba_front.sv */
// Front end: takes request words and queues them for the executor.
module fba_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    input  logic                      i_req_type,
    input  logic [fba_pkg::IDX_W-1:0] i_block_index,
    output logic                      busy,
    output logic                      o_cmd_valid,
    output fba_pkg::t_cmd             o_cmd,
    input  logic                      i_pop
);

    fba_pkg::t_cmd r_slot [fba_pkg::QUEUE_DEPTH];
    logic          r_wr_ptr;
    logic          r_rd_ptr;
    logic [1:0]    r_count;
    logic [1:0]    n_count;
    logic          w_push;
    fba_pkg::t_cmd w_cmd;

    // classify the incoming word
    always_comb begin
        w_cmd.req_type    = fba_pkg::t_req'(i_req_type);
        w_cmd.block_index = i_block_index;
    end

    assign busy        = (r_count == 2'(fba_pkg::QUEUE_DEPTH));
    assign w_push      = start && !busy;
    assign o_cmd_valid = (r_count != 2'd0);
    assign o_cmd       = r_slot[r_rd_ptr];
    assign n_count     = r_count + {1'b0, w_push} - {1'b0, i_pop};

    // advance queue pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= n_count;
        end
    end

    // hold queued words
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr_ptr] <= w_cmd;
        end
    end

endmodule

/* design/fba_back.sv */
// Back end: pool state, link memory and result generation.
module fba_back #(
    parameter int MAX_BLOCKS = fba_pkg::MAX_BLOCKS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_index,
    input  logic [fba_pkg::CFG_W-1:0]   i_cfg_data,
    input  logic                        i_cmd_valid,
    input  fba_pkg::t_cmd               i_cmd,
    output logic                        o_pop,
    output logic                        o_done,
    output logic                        o_granted,
    output logic [fba_pkg::IDX_W-1:0]   o_given_index,
    output logic [fba_pkg::OFS_W-1:0]   o_byte_offset,
    output logic [fba_pkg::CNT_W-1:0]   o_blocks_free
);

    localparam int DEPTH = (MAX_BLOCKS > fba_pkg::POOL_LIMIT) ? fba_pkg::POOL_LIMIT
                                                               : MAX_BLOCKS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [fba_pkg::CNT_W-1:0] LIM = fba_pkg::CNT_W'(DEPTH);

    // clamp the configured count to what the store holds
    function automatic logic [fba_pkg::CNT_W-1:0] eff_count(
        input logic [fba_pkg::CNT_W-1:0] bc
    );
        return (bc > LIM) ? LIM : bc;
    endfunction

    logic [fba_pkg::CNT_W-1:0]   link_mem [DEPTH];

    logic [fba_pkg::CNT_W-1:0]   r_block_count;
    logic [fba_pkg::BYTES_W-1:0] r_block_bytes;
    logic [fba_pkg::IDX_W-1:0]   r_head;
    logic                        r_head_valid;
    logic [fba_pkg::CNT_W-1:0]   r_free_total;
    logic [fba_pkg::CNT_W-1:0]   r_init_total;
    fba_pkg::t_back_state        r_state;
    fba_pkg::t_back_state        n_state;
    logic                        r_done;
    logic                        r_granted;
    logic [fba_pkg::IDX_W-1:0]   r_given;
    logic [fba_pkg::OFS_W-1:0]   r_offset;
    logic [fba_pkg::CNT_W-1:0]   r_blocks_free;
    logic [fba_pkg::CNT_W-1:0]   r_rdata;
    logic                        r_fwd;
    logic [fba_pkg::IDX_W-1:0]   r_fwd_val;
    logic                        r_oob;

    logic                        w_exec;
    logic                        w_alloc;
    logic [fba_pkg::CNT_W-1:0]   w_eff;
    logic                        w_init_ok;
    logic                        w_have;
    logic [fba_pkg::CNT_W-1:0]   w_free_dec;
    logic [fba_pkg::CNT_W-1:0]   w_free_inc;
    logic [fba_pkg::CNT_W-1:0]   w_init_inc;
    logic                        w_idx_in;
    logic                        w_head_in;
    logic                        w_wen;
    logic [AW-1:0]               w_waddr;
    logic [fba_pkg::CNT_W-1:0]   w_wdata;
    logic [fba_pkg::OFS_W-1:0]   w_product;
    logic [fba_pkg::IDX_W-1:0]   w_next_head;

    assign w_alloc    = (i_cmd.req_type == fba_pkg::REQ_ALLOC);
    assign w_eff      = eff_count(r_block_count);
    assign w_init_ok  = (r_init_total < w_eff);
    assign w_have     = (r_free_total != '0);
    assign w_free_dec = r_free_total - 1'b1;
    assign w_free_inc = (r_free_total == fba_pkg::CNT_SAT) ? r_free_total
                                                           : r_free_total + 1'b1;
    assign w_init_inc = r_init_total + 1'b1;
    assign w_idx_in   = (32'(i_cmd.block_index) < 32'(DEPTH));
    assign w_head_in  = (32'(r_head) < 32'(DEPTH));
    assign w_product  = fba_pkg::OFS_W'(r_head) * fba_pkg::OFS_W'(r_block_bytes);
    assign w_next_head = r_oob ? '0 : (r_fwd ? r_fwd_val : r_rdata[fba_pkg::IDX_W-1:0]);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            fba_pkg::BK_EXEC: begin
                if (w_exec && w_alloc && w_have && (w_free_dec != '0)) begin
                    n_state = fba_pkg::BK_LOAD;
                end
            end
            fba_pkg::BK_LOAD: begin
                n_state = fba_pkg::BK_EXEC;
            end
            default: begin
                n_state = fba_pkg::BK_EXEC;
            end
        endcase
    end

    // state outputs
    always_comb begin
        case (r_state)
            fba_pkg::BK_EXEC: w_exec = i_cmd_valid;
            default:          w_exec = 1'b0;
        endcase
    end

    assign o_pop = w_exec;

    // select the link write: lazy init on allocate, push on free
    always_comb begin
        if (w_alloc) begin
            w_wen   = w_exec && w_init_ok;
            w_waddr = r_init_total[AW-1:0];
            w_wdata = w_init_inc;
        end else begin
            w_wen   = w_exec && w_idx_in;
            w_waddr = i_cmd.block_index[AW-1:0];
            w_wdata = r_head_valid ? {1'b0, r_head} : w_eff;
        end
    end

    // link memory, registered read of the head link
    always_ff @(posedge i_clk) begin
        if (w_wen) begin
            link_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= link_mem[r_head[AW-1:0]];
    end

    // capture bypass and range info for the head reload
    always_ff @(posedge i_clk) begin
        r_fwd     <= w_init_ok && ({1'b0, r_head} == r_init_total);
        r_fwd_val <= w_init_inc[fba_pkg::IDX_W-1:0];
        r_oob     <= !w_head_in;
    end

    // pool state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_count <= fba_pkg::CNT_RESET;
            r_block_bytes <= fba_pkg::BYTES_RESET;
            r_head        <= '0;
            r_head_valid  <= 1'b1;
            r_free_total  <= eff_count(fba_pkg::CNT_RESET);
            r_init_total  <= '0;
            r_state       <= fba_pkg::BK_EXEC;
            r_done        <= 1'b0;
        end else if (i_cfg_we) begin
            if (i_cfg_index == fba_pkg::CFG_BLOCK_COUNT) begin
                r_block_count <= i_cfg_data[fba_pkg::CNT_W-1:0];
                r_free_total  <= eff_count(i_cfg_data[fba_pkg::CNT_W-1:0]);
            end else begin
                r_block_bytes <= i_cfg_data[fba_pkg::BYTES_W-1:0];
                r_free_total  <= w_eff;
            end
            r_head       <= '0;
            r_head_valid <= 1'b1;
            r_init_total <= '0;
            r_state      <= fba_pkg::BK_EXEC;
            r_done       <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= w_exec;
            if (r_state == fba_pkg::BK_LOAD) begin
                r_head <= w_next_head;
            end
            if (w_exec) begin
                if (w_alloc) begin
                    if (w_init_ok) begin
                        r_init_total <= w_init_inc;
                    end
                    if (w_have) begin
                        r_free_total <= w_free_dec;
                        if (w_free_dec == '0) begin
                            r_head       <= '0;
                            r_head_valid <= 1'b0;
                        end
                    end
                end else begin
                    r_head       <= i_cmd.block_index;
                    r_head_valid <= 1'b1;
                    r_free_total <= w_free_inc;
                end
            end
        end
    end

    // result word
    always_ff @(posedge i_clk) begin
        if (w_exec) begin
            if (w_alloc) begin
                r_granted     <= w_have;
                r_given       <= w_have ? r_head : '0;
                r_offset      <= w_have ? w_product : '0;
                r_blocks_free <= w_have ? w_free_dec : r_free_total;
            end else begin
                r_granted     <= 1'b1;
                r_given       <= '0;
                r_offset      <= '0;
                r_blocks_free <= w_free_inc;
            end
        end
    end

    assign o_done        = r_done;
    assign o_granted     = r_granted;
    assign o_given_index = r_given;
    assign o_byte_offset = r_offset;
    assign o_blocks_free = r_blocks_free;

    // a head reload is always followed by a return to execute
    a_load_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fba_pkg::BK_LOAD) |=> (r_state == fba_pkg::BK_EXEC))
        else $error("head reload did not return to execute");

    // an empty list means no free blocks
    a_empty_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_head_valid |-> (r_free_total == '0))
        else $error("head invalid while blocks are free");

    // lazy init never runs past the pool size
    a_init_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_init_total <= w_eff)
        else $error("init count beyond pool size");

    // a refused allocate carries no block
    a_refused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_granted) |-> ((o_given_index == '0) && (o_byte_offset == '0)))
        else $error("refused allocate carries a block");

    // every executed word without a configuration write raises the registered o_done
    a_done_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_exec && !i_cfg_we) |=> o_done)
        else $error("executed word gave no result");

endmodule
